FILE: design/hsl_to_rgb_converter_core_macros.svh
// Assertion helpers for the converter's RTL.
`ifndef HSL_TO_RGB_CONVERTER_CORE_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_CORE_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define HRC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hsl_to_rgb_converter_core: assertion failed");

// The condition must never be true at a rising edge outside reset.
`define HRC_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hsl_to_rgb_converter_core: forbidden condition seen");

`endif

FILE: design/hrc_pkg.sv
`timescale 1ns / 1ps

package hrc_pkg;

    localparam int NUM_STAGES = 5;

    localparam int HUE_W     = 16;
    localparam int UNIT_W    = 9;
    localparam int CHAN_W    = 8;
    localparam int QUOT_W    = 8;
    localparam int LEVEL_W   = 17;
    localparam int WEIGHT_W  = 6;
    localparam int PROD_W    = 22;

    localparam int UNIT_ONE  = 256;
    localparam int FULL_TURN = 360;
    localparam int SECTOR    = 60;

    // Bias that moves any signed 16-bit hue into 352..65887, a 17-bit unsigned
    // range, without changing it modulo 360.
    localparam int HUE_BIAS        = 92 * FULL_TURN;
    // Reciprocals: floor(u * RECIP >> SHIFT) is exact over the ranges used here.
    localparam int HUE_RECIP_SHIFT = 24;
    localparam int HUE_RECIP       = ((1 << HUE_RECIP_SHIFT) + FULL_TURN - 1) / FULL_TURN;
    localparam int SEC_RECIP_SHIFT = 28;
    localparam int SEC_RECIP       = ((1 << SEC_RECIP_SHIFT) + SECTOR - 1) / SECTOR;
    // The sector reciprocal needs 23 bits.
    localparam int SEC_PROD_W      = PROD_W + 23;

    typedef logic [HUE_W-1:0]    hue_t;
    typedef logic [UNIT_W-1:0]   unit_t;
    typedef logic [CHAN_W-1:0]   chan_t;
    typedef logic [LEVEL_W-1:0]  level_t;

    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW  = 3'd0,
        SECTOR_YELLOW_GREEN = 3'd1,
        SECTOR_GREEN_CYAN  = 3'd2,
        SECTOR_CYAN_BLUE   = 3'd3,
        SECTOR_BLUE_MAGENTA = 3'd4,
        SECTOR_MAGENTA_RED = 3'd5
    } sector_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctrl_t;

    function automatic unit_t clamp_unit(input unit_t v);
        clamp_unit = (v > unit_t'(UNIT_ONE)) ? unit_t'(UNIT_ONE) : v;
    endfunction

endpackage

FILE: design/hrc_pipe_ctrl.sv
`timescale 1ns / 1ps

module hrc_pipe_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_ready,
    output hrc_pkg::pipe_ctrl_t ctrl
);

    logic [hrc_pkg::NUM_STAGES-1:0] valid_reg;
    logic [hrc_pkg::NUM_STAGES-1:0] valid_next;
    logic [hrc_pkg::NUM_STAGES-1:0] load;

    // A stage loads when it is empty or its word moves on this cycle, so
    // bubbles are squeezed out and nothing is dropped under backpressure.
    always_comb
    begin
        load[hrc_pkg::NUM_STAGES-1] = !valid_reg[hrc_pkg::NUM_STAGES-1] || out_ready;
        for (int i = hrc_pkg::NUM_STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < hrc_pkg::NUM_STAGES; i++)
        begin
            if (load[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load  = load;
    assign ctrl.valid = valid_reg;

endmodule

FILE: design/hrc_hue_wrap.sv
`timescale 1ns / 1ps

module hrc_hue_wrap
(
    input  logic                clk,
    input  logic                load_a,
    input  logic                load_b,
    input  hrc_pkg::hue_t       hue,
    output logic [8:0]          angle
);

    logic [hrc_pkg::HUE_W:0]        shifted;
    logic [2*hrc_pkg::HUE_W-1:0]    quot_prod;
    logic [hrc_pkg::HUE_W:0]        shifted_reg;
    logic [hrc_pkg::QUOT_W-1:0]     quot_reg;
    logic [hrc_pkg::HUE_W:0]        rem_full;
    logic [8:0]                     angle_reg;

    // The biased hue is positive and below 2^17, so plain 17-bit
    // arithmetic on the sign-extended hue gives its exact value.
    always_comb
    begin
        shifted   = {hue[hrc_pkg::HUE_W-1], hue}
                    + (hrc_pkg::HUE_W+1)'(hrc_pkg::HUE_BIAS);
        quot_prod = (2*hrc_pkg::HUE_W)'(shifted)
                    * (2*hrc_pkg::HUE_W)'(hrc_pkg::HUE_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            shifted_reg <= shifted;
            quot_reg    <= quot_prod[hrc_pkg::HUE_RECIP_SHIFT +: hrc_pkg::QUOT_W];
        end
    end

    // The quotient is exact, so the remainder needs no correction step.
    assign rem_full = shifted_reg
                      - (hrc_pkg::HUE_W+1)'(quot_reg) * (hrc_pkg::HUE_W+1)'(hrc_pkg::FULL_TURN);

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            angle_reg <= rem_full[8:0];
        end
    end

    assign angle = angle_reg;

endmodule

FILE: design/hrc_chroma.sv
`timescale 1ns / 1ps

module hrc_chroma
(
    input  logic             clk,
    input  logic             load_a,
    input  logic             load_b,
    input  hrc_pkg::unit_t   saturation,
    input  hrc_pkg::unit_t   lightness,
    output hrc_pkg::level_t  chroma,
    output hrc_pkg::unit_t   lit
);

    hrc_pkg::unit_t         sat_c;
    hrc_pkg::unit_t         lit_c;
    logic [9:0]             twice;
    hrc_pkg::unit_t         lit_gap;
    hrc_pkg::unit_t         span;
    hrc_pkg::unit_t         span_reg;
    hrc_pkg::unit_t         sat_reg;
    hrc_pkg::unit_t         lit_a_reg;
    hrc_pkg::level_t        chroma_reg;
    hrc_pkg::unit_t         lit_b_reg;

    always_comb
    begin
        sat_c = hrc_pkg::clamp_unit(saturation);
        lit_c = hrc_pkg::clamp_unit(lightness);
        twice = {lit_c, 1'b0};
        if (twice >= 10'(hrc_pkg::UNIT_ONE))
        begin
            lit_gap = hrc_pkg::UNIT_W'(twice - 10'(hrc_pkg::UNIT_ONE));
        end
        else
        begin
            lit_gap = hrc_pkg::UNIT_W'(10'(hrc_pkg::UNIT_ONE) - twice);
        end
        span = hrc_pkg::UNIT_W'(hrc_pkg::UNIT_ONE) - lit_gap;
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            span_reg  <= span;
            sat_reg   <= sat_c;
            lit_a_reg <= lit_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            chroma_reg <= hrc_pkg::LEVEL_W'(span_reg) * hrc_pkg::LEVEL_W'(sat_reg);
            lit_b_reg  <= lit_a_reg;
        end
    end

    assign chroma = chroma_reg;
    assign lit    = lit_b_reg;

endmodule

FILE: design/hrc_mix.sv
`timescale 1ns / 1ps

module hrc_mix
(
    input  logic             clk,
    input  logic             load_c,
    input  logic             load_d,
    input  logic             load_e,
    input  logic [8:0]       angle,
    input  hrc_pkg::level_t  chroma,
    input  hrc_pkg::unit_t   lit,
    output hrc_pkg::chan_t   red,
    output hrc_pkg::chan_t   green,
    output hrc_pkg::chan_t   blue
);

    hrc_pkg::sector_t                  sector;
    logic [8:0]                        phase;
    logic [hrc_pkg::WEIGHT_W-1:0]      off;
    logic [hrc_pkg::WEIGHT_W-1:0]      weight;

    hrc_pkg::sector_t                  sector_c_reg;
    logic [hrc_pkg::PROD_W-1:0]        prod_c_reg;
    hrc_pkg::level_t                   chroma_c_reg;
    hrc_pkg::level_t                   base_c_reg;

    logic [hrc_pkg::SEC_PROD_W-1:0]    sec_prod;
    hrc_pkg::sector_t                  sector_d_reg;
    hrc_pkg::level_t                   second_d_reg;
    hrc_pkg::level_t                   chroma_d_reg;
    hrc_pkg::level_t                   base_d_reg;

    hrc_pkg::level_t                   part_r;
    hrc_pkg::level_t                   part_g;
    hrc_pkg::level_t                   part_b;
    hrc_pkg::level_t                   sum_r;
    hrc_pkg::level_t                   sum_g;
    hrc_pkg::level_t                   sum_b;
    logic [24:0]                       scaled_r;
    logic [24:0]                       scaled_g;
    logic [24:0]                       scaled_b;
    hrc_pkg::chan_t                    red_reg;
    hrc_pkg::chan_t                    green_reg;
    hrc_pkg::chan_t                    blue_reg;

    // Sector, and the weight of the secondary part: 60 minus the distance
    // from the middle of the 120-degree period.
    always_comb
    begin
        priority if (angle < 9'(hrc_pkg::SECTOR))
        begin
            sector = hrc_pkg::SECTOR_RED_YELLOW;
        end
        else if (angle < 9'(2 * hrc_pkg::SECTOR))
        begin
            sector = hrc_pkg::SECTOR_YELLOW_GREEN;
        end
        else if (angle < 9'(3 * hrc_pkg::SECTOR))
        begin
            sector = hrc_pkg::SECTOR_GREEN_CYAN;
        end
        else if (angle < 9'(4 * hrc_pkg::SECTOR))
        begin
            sector = hrc_pkg::SECTOR_CYAN_BLUE;
        end
        else if (angle < 9'(5 * hrc_pkg::SECTOR))
        begin
            sector = hrc_pkg::SECTOR_BLUE_MAGENTA;
        end
        else
        begin
            sector = hrc_pkg::SECTOR_MAGENTA_RED;
        end

        priority if (angle < 9'(2 * hrc_pkg::SECTOR))
        begin
            phase = angle;
        end
        else if (angle < 9'(4 * hrc_pkg::SECTOR))
        begin
            phase = angle - 9'(2 * hrc_pkg::SECTOR);
        end
        else
        begin
            phase = angle - 9'(4 * hrc_pkg::SECTOR);
        end

        if (phase >= 9'(hrc_pkg::SECTOR))
        begin
            off = hrc_pkg::WEIGHT_W'(phase - 9'(hrc_pkg::SECTOR));
        end
        else
        begin
            off = hrc_pkg::WEIGHT_W'(9'(hrc_pkg::SECTOR) - phase);
        end
        weight = hrc_pkg::WEIGHT_W'(hrc_pkg::SECTOR) - off;
    end

    always_ff @(posedge clk)
    begin
        if (load_c)
        begin
            sector_c_reg <= sector;
            prod_c_reg   <= hrc_pkg::PROD_W'(hrc_pkg::PROD_W'(chroma)
                                             * hrc_pkg::PROD_W'(weight));
            chroma_c_reg <= chroma;
            // Chroma is always even, so the halving is exact.
            base_c_reg   <= {lit, 8'b0} - (chroma >> 1);
        end
    end

    assign sec_prod = hrc_pkg::SEC_PROD_W'(prod_c_reg)
                      * hrc_pkg::SEC_PROD_W'(hrc_pkg::SEC_RECIP);

    always_ff @(posedge clk)
    begin
        if (load_d)
        begin
            sector_d_reg <= sector_c_reg;
            second_d_reg <= sec_prod[hrc_pkg::SEC_RECIP_SHIFT +: hrc_pkg::LEVEL_W];
            chroma_d_reg <= chroma_c_reg;
            base_d_reg   <= base_c_reg;
        end
    end

    always_comb
    begin
        part_r = '0;
        part_g = '0;
        part_b = '0;
        unique case (sector_d_reg)
            hrc_pkg::SECTOR_RED_YELLOW:
            begin
                part_r = chroma_d_reg;
                part_g = second_d_reg;
            end
            hrc_pkg::SECTOR_YELLOW_GREEN:
            begin
                part_r = second_d_reg;
                part_g = chroma_d_reg;
            end
            hrc_pkg::SECTOR_GREEN_CYAN:
            begin
                part_g = chroma_d_reg;
                part_b = second_d_reg;
            end
            hrc_pkg::SECTOR_CYAN_BLUE:
            begin
                part_g = second_d_reg;
                part_b = chroma_d_reg;
            end
            hrc_pkg::SECTOR_BLUE_MAGENTA:
            begin
                part_r = second_d_reg;
                part_b = chroma_d_reg;
            end
            default:
            begin
                part_r = chroma_d_reg;
                part_b = second_d_reg;
            end
        endcase

        sum_r = part_r + base_d_reg;
        sum_g = part_g + base_d_reg;
        sum_b = part_b + base_d_reg;

        // Times 255 as a shift and a subtract; the level never exceeds 65536.
        scaled_r = {sum_r, 8'b0} - 25'(sum_r);
        scaled_g = {sum_g, 8'b0} - 25'(sum_g);
        scaled_b = {sum_b, 8'b0} - 25'(sum_b);
    end

    always_ff @(posedge clk)
    begin
        if (load_e)
        begin
            red_reg   <= scaled_r[23:16];
            green_reg <= scaled_g[23:16];
            blue_reg  <= scaled_b[23:16];
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

FILE: design/hsl_to_rgb_converter_core.sv
// HSL to RGB converter: one color word in, one RGB word out, in a five-stage
// pipeline that takes a new word every clock unless output backpressure has
// filled every stage. Hue is any signed degree value and is wrapped modulo
// 360; saturation and lightness are in 1/256 units with values above 256
// treated as 256. Output channels are truncated to 0..255.
// Backpressure on the output stalls only the stages that are full, so the
// input stays ready while any stage holds a bubble.
`timescale 1ns / 1ps

`include "hsl_to_rgb_converter_core_macros.svh"

module hsl_to_rgb_converter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // hue[15:0], saturation[24:16], lightness[33:25], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    hrc_pkg::pipe_ctrl_t pipe_ctrl;
    logic [8:0]          angle;
    hrc_pkg::level_t     chroma;
    hrc_pkg::unit_t      lit;
    hrc_pkg::chan_t      red;
    hrc_pkg::chan_t      green;
    hrc_pkg::chan_t      blue;

    hrc_pipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .ctrl      (pipe_ctrl)
    );

    hrc_hue_wrap u_hue
    (
        .clk    (clk),
        .load_a (pipe_ctrl.load[0]),
        .load_b (pipe_ctrl.load[1]),
        .hue    (s_tdata[15:0]),
        .angle  (angle)
    );

    hrc_chroma u_chroma
    (
        .clk        (clk),
        .load_a     (pipe_ctrl.load[0]),
        .load_b     (pipe_ctrl.load[1]),
        .saturation (s_tdata[24:16]),
        .lightness  (s_tdata[33:25]),
        .chroma     (chroma),
        .lit        (lit)
    );

    hrc_mix u_mix
    (
        .clk    (clk),
        .load_c (pipe_ctrl.load[2]),
        .load_d (pipe_ctrl.load[3]),
        .load_e (pipe_ctrl.load[4]),
        .angle  (angle),
        .chroma (chroma),
        .lit    (lit),
        .red    (red),
        .green  (green),
        .blue   (blue)
    );

    assign s_tready = pipe_ctrl.load[0];
    assign m_tvalid = pipe_ctrl.valid[hrc_pkg::NUM_STAGES-1];
    assign m_tdata  = {blue, green, red};

    // Input ready drops only when every stage is full and the output is stalled.
    `HRC_ASSERT(a_ready_low_only_when_stalled, clk, rst_n, !s_tready |-> (m_tvalid && !m_tready))
    `HRC_ASSERT_NEVER(a_ready_low_with_bubble, clk, rst_n, !s_tready && !pipe_ctrl.valid[0])
    // A new output word always comes from a full fourth stage.
    `HRC_ASSERT(a_output_from_stage_four, clk, rst_n, $rose(m_tvalid) |-> $past(pipe_ctrl.valid[3]))

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 340;
    localparam int HOLD_BURST = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        hrc_pkg::chan_t blue;
        hrc_pkg::chan_t green;
        hrc_pkg::chan_t red;
    } rgb_t;

    // Tracks the colors the converter has taken in and checks the RGB words it returns.
    class rgb_scoreboard;
        rgb_t expected_q[$];
        int unsigned mismatches;
        int unsigned checked;

        function hrc_pkg::chan_t scale_level(int unsigned level);
            longint unsigned scaled;
            scaled = longint'(level) * 255;
            return hrc_pkg::chan_t'(scaled >> 16);
        endfunction

        function rgb_t convert(hrc_pkg::hue_t hue, hrc_pkg::unit_t sat_in,
                               hrc_pkg::unit_t lit_in);
            int hv;
            int unsigned sat, lit, twice, gap, chroma, ph, off, second, base;
            int unsigned pr, pg, pb;
            hrc_pkg::sector_t sec;
            rgb_t rgb;
            hv = int'($signed(hue)) % hrc_pkg::FULL_TURN;
            if (hv < 0)
                hv += hrc_pkg::FULL_TURN;
            sat = (sat_in > hrc_pkg::UNIT_ONE) ? hrc_pkg::UNIT_ONE : sat_in;
            lit = (lit_in > hrc_pkg::UNIT_ONE) ? hrc_pkg::UNIT_ONE : lit_in;
            twice = 2 * lit;
            gap = (twice >= hrc_pkg::UNIT_ONE) ? twice - hrc_pkg::UNIT_ONE
                                               : hrc_pkg::UNIT_ONE - twice;
            chroma = (hrc_pkg::UNIT_ONE - gap) * sat;
            ph = hv % (2 * hrc_pkg::SECTOR);
            off = (ph >= hrc_pkg::SECTOR) ? ph - hrc_pkg::SECTOR : hrc_pkg::SECTOR - ph;
            second = (chroma * (hrc_pkg::SECTOR - off)) / hrc_pkg::SECTOR;
            base = lit * hrc_pkg::UNIT_ONE - chroma / 2;
            pr = 0;
            pg = 0;
            pb = 0;
            sec = hrc_pkg::sector_t'(hv / hrc_pkg::SECTOR);
            case (sec)
                hrc_pkg::SECTOR_RED_YELLOW:
                begin
                    pr = chroma;
                    pg = second;
                end
                hrc_pkg::SECTOR_YELLOW_GREEN:
                begin
                    pr = second;
                    pg = chroma;
                end
                hrc_pkg::SECTOR_GREEN_CYAN:
                begin
                    pg = chroma;
                    pb = second;
                end
                hrc_pkg::SECTOR_CYAN_BLUE:
                begin
                    pg = second;
                    pb = chroma;
                end
                hrc_pkg::SECTOR_BLUE_MAGENTA:
                begin
                    pr = second;
                    pb = chroma;
                end
                default:
                begin
                    pr = chroma;
                    pb = second;
                end
            endcase
            rgb.red = scale_level(pr + base);
            rgb.green = scale_level(pg + base);
            rgb.blue = scale_level(pb + base);
            return rgb;
        endfunction

        function void note_color(hrc_pkg::hue_t hue, hrc_pkg::unit_t sat,
                                 hrc_pkg::unit_t lit);
            expected_q.push_back(convert(hue, sat, lit));
        endfunction

        function void check_rgb(logic [23:0] word);
            rgb_t got;
            rgb_t want;
            got = word;
            checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: output word %h with nothing outstanding", $realtime, word);
                return;
            end
            want = expected_q.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: rgb mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                             $realtime, want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    rgb_scoreboard sb;
    int          idle_pct;
    int          stall_pct;
    int          hold_req;
    int          hold_left;
    int          sent;
    int unsigned cycles;

    hsl_to_rgb_converter_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        sb = new();
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out with %0d words outstanding", sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Output side: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_rgb(m_tdata);
    end

    task automatic send_color(input hrc_pkg::hue_t hue, input hrc_pkg::unit_t sat,
                              input hrc_pkg::unit_t lit);
        @(negedge clk);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, lit, sat, hue};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_color(hue, sat, lit);
        sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (hrc_pkg::NUM_STAGES * 4) @(posedge clk);
    endtask

    task automatic send_random_color();
        int             mode;
        int             hv;
        hrc_pkg::hue_t  hue;
        hrc_pkg::unit_t sat;
        hrc_pkg::unit_t lit;
        mode = $urandom_range(9);
        if (mode <= 5)
        begin
            // Typical colors: from two turns below zero to just under three above, in-range levels.
            hv = $urandom_range(1799);
            hv -= 720;
            hue = hv[15:0];
            sat = hrc_pkg::unit_t'($urandom_range(hrc_pkg::UNIT_ONE));
            lit = hrc_pkg::unit_t'($urandom_range(hrc_pkg::UNIT_ONE));
        end
        else if (mode <= 7)
        begin
            hue = hrc_pkg::hue_t'($urandom_range(16'hFFFF));
            sat = hrc_pkg::unit_t'($urandom_range(9'h1FF));
            lit = hrc_pkg::unit_t'($urandom_range(9'h1FF));
        end
        else
        begin
            // Sector boundaries, where the channel roles swap.
            hv = hrc_pkg::SECTOR * int'($urandom_range(12)) - 360
                 + int'($urandom_range(2)) - 1;
            hue = hv[15:0];
            sat = $urandom_range(1) ? hrc_pkg::unit_t'(hrc_pkg::UNIT_ONE)
                                    : hrc_pkg::unit_t'($urandom_range(9'h1FF));
            lit = hrc_pkg::unit_t'($urandom_range(hrc_pkg::UNIT_ONE - 1, 1));
        end
        send_color(hue, sat, lit);
    endtask

    initial
    begin
        int phase_idle[4];
        int phase_stall[4];
        hrc_pkg::hue_t corner_hues[12];
        hrc_pkg::unit_t corner_units[6];

        phase_idle = '{0, 88, 0, 9};
        phase_stall = '{0, 0, 88, 9};
        corner_hues = '{16'h8000, 16'h7FFF, 16'd0, 16'd359, 16'd360, 16'hFFFF,
                        16'hFE98, 16'd60, 16'd120, 16'd180, 16'd240, 16'd300};
        corner_units = '{9'd0, 9'd128, 9'd255, 9'd256, 9'd257, 9'd511};

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        hold_left = 0;
        sent = 0;
        cycles = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Hue extremes and every sector, then the level corners.
        foreach (corner_hues[i])
            send_color(corner_hues[i], 9'd256, 9'd128);
        foreach (corner_units[i])
            send_color(16'd200, corner_units[i], corner_units[5 - i]);
        send_color(16'd30, 9'd511, 9'd511);
        send_color(16'h8000, 9'd0, 9'd0);
        send_color(16'd90, 9'd300, 9'd64);
        drain_results();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            repeat (RANDOM_PER_PHASE) send_random_color();
            drain_results();
        end

        // Hold the output off while the input keeps offering, so the pipe backs up.
        idle_pct = 0;
        stall_pct = 0;
        hold_req = HOLD_CYCLES;
        repeat (HOLD_BURST) send_random_color();
        drain_results();

        $display("Sent %0d colors (corners, four idle/stall mixes, one long output hold-off);",
                 sent);
        $display("checked %0d RGB words, %0d mismatches, %0d left outstanding.",
                 sb.checked, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
